// ===== sv/xcrc_pkg.sv =====
// Package: shared constants, types and the CRC step for the XMODEM-CRC receiver.
package xcrc_pkg;

  localparam int PACKET_BYTES_DEF = 128;
  localparam int SECTOR_BYTES_DEF = 4096;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_ESC = 8'h1b;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int BURST_CW    = $clog2(QUEUE_DEPTH + 2);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SEQ,
    PH_SEQC,
    PH_DATA,
    PH_CRCH,
    PH_CRCL
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_WORD,
    BK_ACK,
    BK_REPLY,
    BK_ACK_END,
    BK_END
  } back_state_t;

  typedef enum logic [1:0] {
    OP_REPLY,
    OP_BURST,
    OP_ACK_END,
    OP_END
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  reply;
    logic        end_status;
    logic [31:0] base;
    logic [31:0] count;
  } cmd_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/xmodem_crc_packet_receiver.sv =====
// Top level: XMODEM-CRC packet receiver with flash-write word output.
//
//   channel  | dir | handshake         | word
//   in_      | in  | in_valid/in_stall | in_rx_byte
//   out_     | out | out_valid/out_stall | kind, reply, erase, address, data, status, count, last
//   cfg_     | in  | cfg_valid/cfg_ready | cfg_data (image start address)
//
// The front end takes one byte per cycle; it stalls while the command queue is full, and
// on payload bytes while an earlier packet's words are still being sent out.
// Each command leaves the queue from the idle state. A good packet then gives each word by a
// buffer read, then the output register, and ends with the ACK; a lone reply or end result
// gives one output, EOT with end two. SECTOR_BYTES must be a power of two; not checked here.
// Reset is synchronous and active low; cfg_ready is always high.
module xmodem_crc_packet_receiver #(
  parameter int PACKET_BYTES = xcrc_pkg::PACKET_BYTES_DEF,
  parameter int SECTOR_BYTES = xcrc_pkg::SECTOR_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_reply_byte,
  output logic        out_erase_sector,
  output logic [31:0] out_write_address,
  output logic [31:0] out_data_word,
  output logic        out_end_status,
  output logic [31:0] out_byte_count,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import xcrc_pkg::*;

  localparam int Words  = (PACKET_BYTES + 3) / 4;
  localparam int WordAw = $clog2(Words);

  logic              q_push, q_ready, q_pop, q_valid;
  cmd_t              q_in_cmd, q_head_cmd;
  logic              burst_done;
  logic              mem_wr_en;
  logic [WordAw-1:0] mem_wr_addr;
  logic [31:0]       mem_wr_data;

  assign cfg_ready = 1'b1;

  xcrc_front #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .q_push      (q_push),
    .q_cmd       (q_in_cmd),
    .q_ready     (q_ready),
    .burst_done  (burst_done),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  xcrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .head_cmd   (q_head_cmd)
  );

  xcrc_back #(
    .PACKET_BYTES(PACKET_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (q_head_cmd),
    .q_pop             (q_pop),
    .burst_done        (burst_done),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_reply_byte    (out_reply_byte),
    .out_erase_sector  (out_erase_sector),
    .out_write_address (out_write_address),
    .out_data_word     (out_data_word),
    .out_end_status    (out_end_status),
    .out_byte_count    (out_byte_count),
    .out_last          (out_last)
  );

endmodule

// ===== sv/xcrc_queue.sv =====
// Command queue between the receive front end and the result back end.
module xcrc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  xcrc_pkg::cmd_t push_cmd,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output xcrc_pkg::cmd_t head_cmd
);
  import xcrc_pkg::*;

  cmd_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_r, wptr_nxt;
  logic [QUEUE_AW-1:0] rptr_r, rptr_nxt;
  logic [QUEUE_CW-1:0] cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign push_ready = cnt_r != QUEUE_CW'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign head_cmd   = entry_r[rptr_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + QUEUE_CW'(do_push) - QUEUE_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/xcrc_front.sv =====
// Front end: header/sequence/CRC parsing, payload packing and command issue.
module xcrc_front #(
  parameter int  PACKET_BYTES = xcrc_pkg::PACKET_BYTES_DEF,
  localparam int Words        = (PACKET_BYTES + 3) / 4,
  localparam int WordAw       = $clog2(Words),
  localparam int PosW         = $clog2(PACKET_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              cfg_valid,
  input  logic [31:0]       cfg_data,
  output logic              q_push,
  output xcrc_pkg::cmd_t    q_cmd,
  input  logic              q_ready,
  input  logic              burst_done,
  output logic              mem_wr_en,
  output logic [WordAw-1:0] mem_wr_addr,
  output logic [31:0]       mem_wr_data
);
  import xcrc_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [PosW-1:0]     pos_r, pos_nxt;
  logic [7:0]          exp_seq_r, exp_seq_nxt;
  logic [7:0]          seq_r, seq_nxt;
  logic [7:0]          seqc_r, seqc_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [7:0]          crch_r, crch_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [31:0]         addr_r, addr_nxt;
  logic [31:0]         total_r, total_nxt;
  logic                finished_r, finished_nxt;
  logic                accepted_r, accepted_nxt;
  logic [BURST_CW-1:0] burst_cnt_r, burst_cnt_nxt;

  logic        act;
  logic        pos_last;
  logic        crc_ok;
  logic [15:0] crc_step;
  logic [31:0] acc_merge;

  assign in_stall = ~q_ready | ((phase_r == PH_DATA) & (burst_cnt_r != '0));
  assign act      = in_valid & ~in_stall & ~finished_r;
  assign pos_last = pos_r == PosW'(PACKET_BYTES - 1);
  assign crc_step = crc16_byte(crc_r, in_rx_byte);
  assign crc_ok   = ({crch_r, in_rx_byte} == crc_r) && (seq_r == exp_seq_r)
                    && (seqc_r == ~exp_seq_r);
  assign acc_merge = ((pos_r[1:0] == 2'd0) ? 32'd0 : acc_r)
                     | ({24'd0, in_rx_byte} << {pos_r[1:0], 3'b000});

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER: if (act && in_rx_byte == CH_SOH) phase_nxt = PH_SEQ;
      PH_SEQ:    if (act) phase_nxt = PH_SEQC;
      PH_SEQC:   if (act) phase_nxt = PH_DATA;
      PH_DATA:   if (act && pos_last) phase_nxt = PH_CRCH;
      PH_CRCH:   if (act) phase_nxt = PH_CRCL;
      PH_CRCL:   if (act) phase_nxt = PH_HEADER;
      default:   phase_nxt = PH_HEADER;
    endcase
  end

  // datapath and command issue
  always_comb begin
    pos_nxt      = pos_r;
    exp_seq_nxt  = exp_seq_r;
    seq_nxt      = seq_r;
    seqc_nxt     = seqc_r;
    crc_nxt      = crc_r;
    crch_nxt     = crch_r;
    acc_nxt      = acc_r;
    addr_nxt     = addr_r;
    total_nxt    = total_r;
    finished_nxt = finished_r;
    accepted_nxt = accepted_r;
    q_push       = 1'b0;
    q_cmd.op         = OP_REPLY;
    q_cmd.reply      = CH_NAK;
    q_cmd.end_status = 1'b0;
    q_cmd.base       = addr_r;
    q_cmd.count      = total_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = WordAw'(pos_r[PosW-1:2]);
    mem_wr_data  = acc_merge;
    if (act) begin
      case (phase_r)
        PH_HEADER: begin
          if (in_rx_byte == CH_SOH) begin
            pos_nxt = '0;
            crc_nxt = '0;
          end else if (in_rx_byte == CH_EOT) begin
            q_push      = 1'b1;
            q_cmd.reply = CH_ACK;
            if (total_r != 32'd0) begin
              q_cmd.op     = OP_ACK_END;
              finished_nxt = 1'b1;
            end
          end else if (in_rx_byte == CH_CAN || in_rx_byte == CH_ESC) begin
            q_push           = 1'b1;
            q_cmd.op         = OP_END;
            q_cmd.end_status = 1'b1;
            finished_nxt     = 1'b1;
          end else begin
            q_push = 1'b1;
          end
        end
        PH_SEQ:  seq_nxt = in_rx_byte;
        PH_SEQC: seqc_nxt = in_rx_byte;
        PH_DATA: begin
          acc_nxt   = acc_merge;
          crc_nxt   = crc_step;
          mem_wr_en = (pos_r[1:0] == 2'd3) | pos_last;
          pos_nxt   = pos_last ? '0 : pos_r + 1'b1;
        end
        PH_CRCH: crch_nxt = in_rx_byte;
        PH_CRCL: begin
          q_push = 1'b1;
          if (crc_ok) begin
            q_cmd.op     = OP_BURST;
            q_cmd.reply  = CH_ACK;
            q_cmd.count  = total_r + 32'(PACKET_BYTES);
            exp_seq_nxt  = exp_seq_r + 8'd1;
            addr_nxt     = addr_r + 32'(PACKET_BYTES);
            total_nxt    = total_r + 32'(PACKET_BYTES);
            accepted_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cfg_valid && !accepted_r) begin
      addr_nxt = cfg_data;
    end
    burst_cnt_nxt = burst_cnt_r + BURST_CW'(q_push && q_cmd.op == OP_BURST)
                    - BURST_CW'(burst_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pos_r       <= '0;
      exp_seq_r   <= 8'd1;
      crc_r       <= '0;
      addr_r      <= '0;
      total_r     <= '0;
      finished_r  <= 1'b0;
      accepted_r  <= 1'b0;
      burst_cnt_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      exp_seq_r   <= exp_seq_nxt;
      crc_r       <= crc_nxt;
      addr_r      <= addr_nxt;
      total_r     <= total_nxt;
      finished_r  <= finished_nxt;
      accepted_r  <= accepted_nxt;
      burst_cnt_r <= burst_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r  <= seq_nxt;
    seqc_r <= seqc_nxt;
    crch_r <= crch_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

// ===== sv/xcrc_back.sv =====
// Back end: payload word buffer and result sequencer with output register.
module xcrc_back #(
  parameter int  PACKET_BYTES = xcrc_pkg::PACKET_BYTES_DEF,
  parameter int  SECTOR_BYTES = xcrc_pkg::SECTOR_BYTES_DEF,
  localparam int Words        = (PACKET_BYTES + 3) / 4,
  localparam int WordAw       = $clog2(Words),
  localparam int SectorAw     = $clog2(SECTOR_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  xcrc_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              burst_done,
  input  logic              mem_wr_en,
  input  logic [WordAw-1:0] mem_wr_addr,
  input  logic [31:0]       mem_wr_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_reply_byte,
  output logic              out_erase_sector,
  output logic [31:0]       out_write_address,
  output logic [31:0]       out_data_word,
  output logic              out_end_status,
  output logic [31:0]       out_byte_count,
  output logic              out_last
);
  import xcrc_pkg::*;

  logic [31:0] mem [Words];
  logic [31:0] rd_data_r;

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [WordAw-1:0] widx_r, widx_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [7:0]        reply_r, reply_nxt;
  logic              erase_r, erase_nxt;
  logic [31:0]       waddr_r, waddr_nxt;
  logic [31:0]       data_r, data_nxt;
  logic              status_r, status_nxt;
  logic [31:0]       count_r, count_nxt;
  logic              last_r, last_nxt;

  logic slot_free;
  logic rd_en;
  logic word_last;

  assign slot_free = ~out_valid_r | ~out_stall;
  assign word_last = widx_r == WordAw'(Words - 1);
  assign q_pop     = (state_r == BK_IDLE) & q_valid;
  assign rd_en     = state_r == BK_READ;

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[widx_r];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_BURST:   state_nxt = BK_READ;
            OP_ACK_END: state_nxt = BK_ACK_END;
            OP_END:     state_nxt = BK_END;
            default:    state_nxt = BK_REPLY;
          endcase
        end
      end
      BK_READ:    state_nxt = BK_WORD;
      BK_WORD:    if (slot_free) state_nxt = word_last ? BK_ACK : BK_READ;
      BK_ACK:     if (slot_free) state_nxt = BK_IDLE;
      BK_REPLY:   if (slot_free) state_nxt = BK_IDLE;
      BK_ACK_END: if (slot_free) state_nxt = BK_END;
      BK_END:     if (slot_free) state_nxt = BK_IDLE;
      default:    state_nxt = BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_nxt       = q_pop ? q_cmd : cmd_r;
    widx_nxt      = q_pop ? '0 : widx_r;
    addr_nxt      = q_pop ? q_cmd.base : addr_r;
    out_valid_nxt = out_valid_r & out_stall;
    kind_nxt      = kind_r;
    reply_nxt     = reply_r;
    erase_nxt     = erase_r;
    waddr_nxt     = waddr_r;
    data_nxt      = data_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    burst_done    = 1'b0;
    if (slot_free) begin
      case (state_r)
        BK_WORD: begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_WRITE;
          reply_nxt     = 8'd0;
          erase_nxt     = addr_r[SectorAw-1:0] == '0;
          waddr_nxt     = addr_r;
          data_nxt      = rd_data_r;
          status_nxt    = 1'b0;
          count_nxt     = cmd_r.count;
          last_nxt      = 1'b0;
          widx_nxt      = widx_r + 1'b1;
          addr_nxt      = addr_r + 32'd4;
        end
        BK_ACK, BK_REPLY, BK_ACK_END: begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_REPLY;
          reply_nxt     = (state_r == BK_REPLY) ? cmd_r.reply : CH_ACK;
          erase_nxt     = 1'b0;
          waddr_nxt     = 32'd0;
          data_nxt      = 32'd0;
          status_nxt    = 1'b0;
          count_nxt     = cmd_r.count;
          last_nxt      = state_r != BK_ACK_END;
          burst_done    = state_r == BK_ACK;
        end
        BK_END: begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_END;
          reply_nxt     = 8'd0;
          erase_nxt     = 1'b0;
          waddr_nxt     = 32'd0;
          data_nxt      = 32'd0;
          status_nxt    = cmd_r.end_status;
          count_nxt     = cmd_r.count;
          last_nxt      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    widx_r   <= widx_nxt;
    addr_r   <= addr_nxt;
    kind_r   <= kind_nxt;
    reply_r  <= reply_nxt;
    erase_r  <= erase_nxt;
    waddr_r  <= waddr_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
    count_r  <= count_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_reply_byte    = reply_r;
  assign out_erase_sector  = erase_r;
  assign out_write_address = waddr_r;
  assign out_data_word     = data_r;
  assign out_end_status    = status_r;
  assign out_byte_count    = count_r;
  assign out_last          = last_r;

endmodule

// ===== sim/tb.sv =====
// Testbench for the XMODEM-CRC packet receiver: byte streams checked against a behavioral model.
module tb;
  import xcrc_pkg::*;

  localparam int PKT         = PACKET_BYTES_DEF;
  localparam int SECTOR      = SECTOR_BYTES_DEF;
  localparam int WORDS       = (PKT + 3) / 4;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 40;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  reply;
    logic        erase;
    logic [31:0] addr;
    logic [31:0] data;
    logic        status;
    logic [31:0] count;
    logic        last;
  } result_t;

  typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_SEQ, FLAW_SEQ_INV} flaw_t;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_reply_byte;
  logic        out_erase_sector;
  logic [31:0] out_write_address;
  logic [31:0] out_data_word;
  logic        out_end_status;
  logic [31:0] out_byte_count;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  xmodem_crc_packet_receiver #(
    .PACKET_BYTES(PKT),
    .SECTOR_BYTES(SECTOR)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_reply_byte   (out_reply_byte),
    .out_erase_sector (out_erase_sector),
    .out_write_address(out_write_address),
    .out_data_word    (out_data_word),
    .out_end_status   (out_end_status),
    .out_byte_count   (out_byte_count),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // receiver model state
  phase_t      m_phase;
  int unsigned m_pos;
  logic [7:0]  m_next_seq;
  logic [7:0]  m_seq;
  logic [7:0]  m_seq_inv;
  logic [7:0]  m_crc_hi;
  logic [15:0] m_crc;
  logic [31:0] m_payload [WORDS];
  logic [31:0] m_base;
  logic [31:0] m_addr;
  logic [31:0] m_total;
  bit          m_done;
  bit          m_any_ok;

  result_t     pending_results[$];
  int          errors = 0;
  int unsigned items_sent = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned hold_left = 0;

  function automatic logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
    for (int i = 7; i >= 0; i--) begin
      logic fb;
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic result_t make_result(logic [1:0] kind, logic [7:0] reply, logic erase,
                                          logic [31:0] addr, logic [31:0] data, logic status);
    result_t r;
    r.kind   = kind;
    r.reply  = reply;
    r.erase  = erase;
    r.addr   = addr;
    r.data   = data;
    r.status = status;
    r.count  = '0;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic void model_reset();
    m_phase    = PH_HEADER;
    m_pos      = 0;
    m_next_seq = 8'd1;
    m_seq      = '0;
    m_seq_inv  = '0;
    m_crc_hi   = '0;
    m_crc      = '0;
    foreach (m_payload[i]) m_payload[i] = '0;
    m_base     = '0;
    m_addr     = '0;
    m_total    = '0;
    m_done     = 1'b0;
    m_any_ok   = 1'b0;
  endfunction

  task automatic rx_model_byte(input logic [7:0] b);
    result_t     res[$];
    logic [31:0] a;
    if (m_done) return;
    case (m_phase)
      PH_HEADER: begin
        if (b == CH_SOH) begin
          m_phase = PH_SEQ;
          m_pos   = 0;
          m_crc   = '0;
          foreach (m_payload[i]) m_payload[i] = '0;
        end else if (b == CH_EOT) begin
          res.push_back(make_result(KIND_REPLY, CH_ACK, 1'b0, '0, '0, 1'b0));
          if (m_total != 0) begin
            res.push_back(make_result(KIND_END, 8'h00, 1'b0, '0, '0, 1'b0));
            m_done = 1'b1;
          end
        end else if (b == CH_CAN || b == CH_ESC) begin
          res.push_back(make_result(KIND_END, 8'h00, 1'b0, '0, '0, 1'b1));
          m_done = 1'b1;
        end else begin
          res.push_back(make_result(KIND_REPLY, CH_NAK, 1'b0, '0, '0, 1'b0));
        end
      end
      PH_SEQ: begin
        m_seq   = b;
        m_phase = PH_SEQC;
      end
      PH_SEQC: begin
        m_seq_inv = b;
        m_phase   = PH_DATA;
      end
      PH_DATA: begin
        m_payload[m_pos / 4][8 * (m_pos % 4) +: 8] = b;
        m_crc = crc_update(m_crc, b);
        if (m_pos + 1 >= PKT) begin
          m_pos   = 0;
          m_phase = PH_CRCH;
        end else begin
          m_pos++;
        end
      end
      PH_CRCH: begin
        m_crc_hi = b;
        m_phase  = PH_CRCL;
      end
      default: begin
        m_phase = PH_HEADER;
        if ({m_crc_hi, b} == m_crc && m_seq == m_next_seq && m_seq_inv == ~m_next_seq) begin
          for (int k = 0; k < WORDS; k++) begin
            a = m_addr + 32'(k) * 32'd4;
            res.push_back(make_result(KIND_WRITE, 8'h00, (a % 32'(SECTOR)) == 0, a,
                                      m_payload[k], 1'b0));
          end
          res.push_back(make_result(KIND_REPLY, CH_ACK, 1'b0, '0, '0, 1'b0));
          m_next_seq++;
          m_addr   += 32'(PKT);
          m_total  += 32'(PKT);
          m_any_ok  = 1'b1;
        end else begin
          res.push_back(make_result(KIND_REPLY, CH_NAK, 1'b0, '0, '0, 1'b0));
        end
      end
    endcase
    foreach (res[k]) begin
      res[k].count = m_total;
      res[k].last  = (k == res.size() - 1);
      pending_results.push_back(res[k]);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b inside {CH_SOH, CH_EOT, CH_CAN, CH_ESC});
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (tx_idle_en && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    rx_model_byte(b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_start_address(input logic [31:0] value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_base = value;
    if (!m_any_ok) m_addr = value;
  endtask

  task automatic send_packet(input flaw_t flaw, input fill_t fill);
    logic [7:0]  body [PKT];
    logic [7:0]  seq;
    logic [7:0]  seq_inv;
    logic [15:0] crc;
    crc = '0;
    seq = m_next_seq;
    if (flaw == FLAW_SEQ) begin
      seq = ($urandom_range(0, 1) != 0) ? m_next_seq - 8'd1
                                        : m_next_seq + 8'($urandom_range(1, 255));
    end
    seq_inv = ~seq;
    if (flaw == FLAW_SEQ_INV) seq_inv ^= 8'($urandom_range(1, 255));
    foreach (body[i]) begin
      case (fill)
        FILL_ZERO: body[i] = 8'h00;
        FILL_ONES: body[i] = 8'hff;
        default: begin
          case ($urandom_range(0, 19))
            0:       body[i] = CH_SOH;
            1:       body[i] = CH_EOT;
            2:       body[i] = CH_CAN;
            3:       body[i] = CH_ESC;
            default: body[i] = 8'($urandom);
          endcase
        end
      endcase
      crc = crc_update(crc, body[i]);
    end
    if (flaw == FLAW_CRC) crc ^= 16'd1 << $urandom_range(0, 15);
    send_byte(CH_SOH);
    send_byte(seq);
    send_byte(seq_inv);
    foreach (body[i]) send_byte(body[i]);
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  // header-phase bytes before any data: NAKs, and EOT that only gets ACK
  task automatic test_header_bytes();
    logic [7:0] probes [11] = '{8'h00, 8'hff, CH_NAK, CH_ACK, CH_EOT, 8'h02, 8'h7f,
                                8'h80, CH_EOT, 8'h55, 8'haa};
    foreach (probes[i]) send_byte(probes[i]);
  endtask

  // start address reloads until the first good packet; chosen to wrap past 2^32
  task automatic test_start_address();
    write_start_address(32'hffff_ffff);
    write_start_address(32'h0000_0000);
    write_start_address(32'hffff_ff80);
    send_packet(FLAW_NONE, FILL_ONES);
  endtask

  task automatic test_random_packets();
    int unsigned stop_at;
    int unsigned pick;
    fill_t       fill;
    stop_at = items_sent + 90;
    while (items_sent < stop_at) begin
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      fill = FILL_RANDOM;
      if ($urandom_range(0, 7) == 0) fill = ($urandom_range(0, 1) != 0) ? FILL_ZERO : FILL_ONES;
      pick = $urandom_range(0, 9);
      case (pick)
        6:       send_packet(FLAW_CRC, fill);
        7:       send_packet(FLAW_SEQ, fill);
        8:       send_packet(FLAW_SEQ_INV, fill);
        9:       repeat ($urandom_range(1, 4)) send_byte(noise_byte());
        default: send_packet(FLAW_NONE, fill);
      endcase
    end
  endtask

  // once a packet is taken the start address write is accepted but no longer moves the address
  task automatic test_base_rewrite();
    write_start_address($urandom);
    send_byte(noise_byte());
    send_byte(noise_byte());
  endtask

  task automatic test_stall_pressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    wait_drained();
    hold_left = 600;
    send_packet(FLAW_NONE, FILL_RANDOM);
    repeat (8) send_byte(noise_byte());
    wait_drained();
  endtask

  // one ending per run, then everything is ignored
  task automatic test_session_end();
    logic [7:0] closer;
    case ($urandom_range(0, 2))
      0:       closer = CH_EOT;
      1:       closer = CH_CAN;
      default: closer = CH_ESC;
    endcase
    send_byte(closer);
    send_byte(CH_SOH);
    send_byte(CH_EOT);
    send_byte(noise_byte());
    send_byte(8'hff);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    int unsigned burst;
    burst = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_results.size() == 0) begin
          errors++;
          $error("unexpected word: kind %0d", out_kind);
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("reply_byte", want.reply, out_reply_byte);
          check_field("erase_sector", want.erase, out_erase_sector);
          check_field("write_address", want.addr, out_write_address);
          check_field("data_word", want.data, out_data_word);
          check_field("end_status", want.status, out_end_status);
          check_field("byte_count", want.count, out_byte_count);
          check_field("last", want.last, out_last);
        end
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    cfg_valid  <= 1'b0;
    cfg_data   <= 32'h0;
    model_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_bytes();
    test_start_address();
    test_random_packets();
    test_base_rewrite();
    test_stall_pressure();
    test_session_end();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
